// File: hw/rtl/fita_pkg.sv
// Package for the format integer to ASCII unit.
// Holds shared constants, the controller state type, the command and status
// structs, and the digit-to-character function. Depends on nothing.
package fita_pkg;

    // Field widths.
    localparam int CHAR_W  = 8;
    localparam int VALUE_W = 32;
    localparam int TOTAL_W = 32;
    localparam int DIGIT_W = 4;
    localparam int S_DATA_W = CHAR_W + VALUE_W;
    localparam int M_DATA_W = CHAR_W + TOTAL_W;

    // Digit scratch store.
    localparam int MAX_DIGITS = 11;
    localparam int DCNT_W     = $clog2(MAX_DIGITS + 1);

    // Prefix characters ahead of the digits: at most two.
    localparam int PCNT_W = 2;

    // Reciprocal of ten, scaled by 2^35, for the divide-by-ten step.
    localparam logic [VALUE_W-1:0] RECIP_10 = 32'hCCCC_CCCD;
    localparam int RECIP_SHIFT = 35;

    // Character codes.
    localparam logic [CHAR_W-1:0] CHAR_PERCENT = 8'h25;
    localparam logic [CHAR_W-1:0] CHAR_MINUS   = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_D       = 8'h64;
    localparam logic [CHAR_W-1:0] CHAR_I       = 8'h69;
    localparam logic [CHAR_W-1:0] CHAR_U       = 8'h75;
    localparam logic [CHAR_W-1:0] CHAR_O       = 8'h6F;
    localparam logic [CHAR_W-1:0] CHAR_X_LOW   = 8'h78;
    localparam logic [CHAR_W-1:0] CHAR_X_UP    = 8'h58;

    // Number base of a conversion.
    typedef enum logic [1:0] {
        BASE_DEC,
        BASE_OCT,
        BASE_HEX
    } base_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_EMIT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // take the input request and decode it
        logic convert;  // produce one digit
        logic emit;     // load the next character into the output register
    } fita_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic arm;          // input request only arms the percent flag
        logic has_digits;   // input request needs a digit conversion
        logic convert_done; // the digit being produced is the last one
        logic out_free;     // output register can take a character
        logic emit_last;    // character being emitted ends the run
    } fita_status_t;

    // Maps one digit to its ASCII character.
    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] digit,
                                                     input logic upper);
        logic [CHAR_W-1:0] ext;
        ext = {{(CHAR_W - DIGIT_W){1'b0}}, digit};
        if (digit < 4'd10) begin
            return CHAR_ZERO + ext;
        end else if (upper) begin
            return CHAR_UPPER_A + ext - 8'd10;
        end else begin
            return CHAR_LOWER_A + ext - 8'd10;
        end
    endfunction

endpackage

// File: hw/rtl/fita_ctrl.sv
// Controller state machine of the format integer to ASCII unit.
// Sequences decode, digit conversion and character output.
// Depends on fita_pkg.
module fita_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    output fita_pkg::fita_cmd_t   cmd,
    input  fita_pkg::fita_status_t status
);

    fita_pkg::state_t state_reg;
    fita_pkg::state_t state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= fita_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            fita_pkg::ST_IDLE: begin
                if (s_tvalid && !status.arm) begin
                    state_next = status.has_digits ? fita_pkg::ST_CONVERT
                                                   : fita_pkg::ST_EMIT;
                end
            end
            fita_pkg::ST_CONVERT: begin
                if (status.convert_done) begin
                    state_next = fita_pkg::ST_EMIT;
                end
            end
            fita_pkg::ST_EMIT: begin
                if (status.out_free && status.emit_last) begin
                    state_next = fita_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = fita_pkg::ST_IDLE;
            end
        endcase
    end

    // Output logic.
    always_comb begin
        s_tready    = 1'b0;
        cmd         = '0;
        unique case (state_reg)
            fita_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            fita_pkg::ST_CONVERT: begin
                cmd.convert = 1'b1;
            end
            fita_pkg::ST_EMIT: begin
                cmd.emit = status.out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

// File: hw/rtl/fita_datapath.sv
// Datapath of the format integer to ASCII unit: decode, digit conversion,
// digit store, running total and the output register.
// Depends on fita_pkg.
module fita_datapath (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic [fita_pkg::S_DATA_W-1:0]        s_tdata,
    input  fita_pkg::fita_cmd_t                  cmd,
    output fita_pkg::fita_status_t               status,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [fita_pkg::M_DATA_W-1:0]        m_tdata,
    output logic                                 m_tlast
);

    // Input fields.
    logic [fita_pkg::CHAR_W-1:0]  fmt_char;
    logic [fita_pkg::VALUE_W-1:0] arg_value;

    // Item state.
    logic                              pending_reg;
    logic                              pending_next;
    logic [fita_pkg::VALUE_W-1:0]      val_reg;
    logic [fita_pkg::VALUE_W-1:0]      val_next;
    fita_pkg::base_t                   base_reg;
    fita_pkg::base_t                   base_next;
    logic                              upper_reg;
    logic                              upper_next;
    logic [fita_pkg::PCNT_W-1:0]       pre_cnt_reg;
    logic [fita_pkg::PCNT_W-1:0]       pre_cnt_next;
    logic [fita_pkg::CHAR_W-1:0]       pre0_reg;
    logic [fita_pkg::CHAR_W-1:0]       pre0_next;
    logic [fita_pkg::CHAR_W-1:0]       pre1_reg;
    logic [fita_pkg::CHAR_W-1:0]       pre1_next;
    logic [fita_pkg::DCNT_W-1:0]       dig_cnt_reg;
    logic [fita_pkg::DCNT_W-1:0]       dig_cnt_next;
    logic [fita_pkg::DIGIT_W-1:0]      digit_store [fita_pkg::MAX_DIGITS];
    logic [fita_pkg::TOTAL_W-1:0]      total_reg;
    logic [fita_pkg::TOTAL_W-1:0]      total_next;

    // Output register.
    logic                              m_valid_reg;
    logic                              m_valid_next;
    logic [fita_pkg::CHAR_W-1:0]       m_char_reg;
    logic [fita_pkg::CHAR_W-1:0]       m_char_next;
    logic                              m_last_reg;
    logic                              m_last_next;
    logic [fita_pkg::TOTAL_W-1:0]      m_total_reg;

    // Decode results.
    logic                              dec_digits;
    fita_pkg::base_t                   dec_base;
    logic                              dec_upper;
    logic                              dec_neg;
    logic [fita_pkg::PCNT_W-1:0]       dec_pre_cnt;
    logic [fita_pkg::CHAR_W-1:0]       dec_pre0;
    logic [fita_pkg::CHAR_W-1:0]       dec_pre1;

    // Conversion step.
    logic [2*fita_pkg::VALUE_W-1:0]    prod;
    logic [fita_pkg::VALUE_W-1:0]      quot;
    logic [fita_pkg::VALUE_W-1:0]      quot_x10;
    logic [fita_pkg::VALUE_W-1:0]      rem_full;
    logic [fita_pkg::DIGIT_W-1:0]      digit;

    // Emit step.
    logic [fita_pkg::DCNT_W-1:0]       remaining;
    logic [fita_pkg::DCNT_W-1:0]       rd_idx;
    logic [fita_pkg::CHAR_W-1:0]       emit_char;

    assign fmt_char  = s_tdata[fita_pkg::CHAR_W-1:0];
    assign arg_value = s_tdata[fita_pkg::S_DATA_W-1:fita_pkg::CHAR_W];

    // Decode the format byte against the percent flag.
    always_comb begin
        dec_digits  = 1'b0;
        dec_base    = fita_pkg::BASE_DEC;
        dec_upper   = 1'b0;
        dec_neg     = 1'b0;
        dec_pre_cnt = 2'd1;
        dec_pre0    = fmt_char;
        dec_pre1    = fmt_char;
        if (pending_reg) begin
            dec_pre_cnt = 2'd0;
            unique case (fmt_char) inside
                fita_pkg::CHAR_D, fita_pkg::CHAR_I: begin
                    dec_digits = 1'b1;
                    dec_neg    = arg_value[fita_pkg::VALUE_W-1];
                    if (dec_neg) begin
                        dec_pre_cnt = 2'd1;
                        dec_pre0    = fita_pkg::CHAR_MINUS;
                    end
                end
                fita_pkg::CHAR_U: begin
                    dec_digits = 1'b1;
                end
                fita_pkg::CHAR_O: begin
                    dec_digits = 1'b1;
                    dec_base   = fita_pkg::BASE_OCT;
                end
                fita_pkg::CHAR_X_LOW: begin
                    dec_digits = 1'b1;
                    dec_base   = fita_pkg::BASE_HEX;
                end
                fita_pkg::CHAR_X_UP: begin
                    dec_digits = 1'b1;
                    dec_base   = fita_pkg::BASE_HEX;
                    dec_upper  = 1'b1;
                end
                fita_pkg::CHAR_PERCENT: begin
                    dec_pre_cnt = 2'd1;
                    dec_pre0    = fita_pkg::CHAR_PERCENT;
                end
                default: begin
                    dec_pre_cnt = 2'd2;
                    dec_pre0    = fita_pkg::CHAR_PERCENT;
                    dec_pre1    = fmt_char;
                end
            endcase
        end
    end

    // One digit per step: divide by ten through the reciprocal, or shift.
    always_comb begin
        prod     = {{fita_pkg::VALUE_W{1'b0}}, val_reg}
                 * {{fita_pkg::VALUE_W{1'b0}}, fita_pkg::RECIP_10};
        quot     = val_reg;
        quot_x10 = '0;
        rem_full = '0;
        digit    = '0;
        case (base_reg)
            fita_pkg::BASE_OCT: begin
                quot  = val_reg >> 3;
                digit = {1'b0, val_reg[2:0]};
            end
            fita_pkg::BASE_HEX: begin
                quot  = val_reg >> 4;
                digit = val_reg[3:0];
            end
            default: begin
                quot     = {{fita_pkg::RECIP_SHIFT - fita_pkg::VALUE_W{1'b0}},
                            prod[2*fita_pkg::VALUE_W-1:fita_pkg::RECIP_SHIFT]};
                quot_x10 = (quot << 3) + (quot << 1);
                rem_full = val_reg - quot_x10;
                digit    = rem_full[fita_pkg::DIGIT_W-1:0];
            end
        endcase
    end

    // Character selection for the emit step.
    always_comb begin
        remaining = {{(fita_pkg::DCNT_W - fita_pkg::PCNT_W){1'b0}}, pre_cnt_reg}
                  + dig_cnt_reg;
        rd_idx    = dig_cnt_reg - 4'd1;
        if (pre_cnt_reg != 2'd0) begin
            emit_char = pre0_reg;
        end else begin
            emit_char = fita_pkg::digit_char(digit_store[rd_idx], upper_reg);
        end
    end

    // Status to the controller.
    always_comb begin
        status.arm          = !pending_reg && (fmt_char == fita_pkg::CHAR_PERCENT);
        status.has_digits   = dec_digits;
        status.convert_done = (quot == '0)
                            || (dig_cnt_reg == fita_pkg::DCNT_W'(fita_pkg::MAX_DIGITS - 1));
        status.out_free     = !m_valid_reg || m_tready;
        status.emit_last    = (remaining == 4'd1);
    end

    // Next values of the item state and output register.
    always_comb begin
        pending_next = pending_reg;
        val_next     = val_reg;
        base_next    = base_reg;
        upper_next   = upper_reg;
        pre_cnt_next = pre_cnt_reg;
        pre0_next    = pre0_reg;
        pre1_next    = pre1_reg;
        dig_cnt_next = dig_cnt_reg;
        total_next   = total_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_char_next  = m_char_reg;
        m_last_next  = m_last_reg;

        if (cmd.load) begin
            pending_next = !pending_reg && (fmt_char == fita_pkg::CHAR_PERCENT);
            val_next     = dec_neg ? (~arg_value + 32'd1) : arg_value;
            base_next    = dec_base;
            upper_next   = dec_upper;
            pre_cnt_next = dec_pre_cnt;
            pre0_next    = dec_pre0;
            pre1_next    = dec_pre1;
            dig_cnt_next = '0;
        end

        if (cmd.convert) begin
            val_next     = quot;
            dig_cnt_next = dig_cnt_reg + 4'd1;
        end

        if (cmd.emit) begin
            if (pre_cnt_reg != 2'd0) begin
                pre_cnt_next = pre_cnt_reg - 2'd1;
                pre0_next    = pre1_reg;
            end else begin
                dig_cnt_next = dig_cnt_reg - 4'd1;
            end
            if (total_reg != {fita_pkg::TOTAL_W{1'b1}}) begin
                total_next = total_reg + 32'd1;
            end
            m_valid_next = 1'b1;
            m_char_next  = emit_char;
            m_last_next  = (remaining == 4'd1);
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= 1'b0;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
            pre_cnt_reg <= '0;
            dig_cnt_reg <= '0;
        end else begin
            pending_reg <= pending_next;
            total_reg   <= total_next;
            m_valid_reg <= m_valid_next;
            pre_cnt_reg <= pre_cnt_next;
            dig_cnt_reg <= dig_cnt_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        val_reg    <= val_next;
        base_reg   <= base_next;
        upper_reg  <= upper_next;
        pre0_reg   <= pre0_next;
        pre1_reg   <= pre1_next;
        m_char_reg <= m_char_next;
        m_last_reg <= m_last_next;
        if (cmd.emit) begin
            m_total_reg <= total_next;
        end
    end

    // Digit store, least significant digit first.
    always_ff @(posedge aclk) begin
        if (cmd.convert) begin
            digit_store[dig_cnt_reg] <= digit;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_total_reg, m_char_reg};
    assign m_tlast  = m_last_reg;

endmodule

// File: hw/rtl/format_integer_to_ascii_unit.sv
// Top level of the format integer to ASCII unit.
// Joins the controller and the datapath. Depends on fita_pkg, fita_ctrl
// and fita_datapath.
//
//  Channel | Direction | tdata (low bit up)              | tlast
//  --------+-----------+---------------------------------+-----------------------
//  s_      | in        | fmt_char[7:0], arg_value[39:8]  | -
//  m_      | out       | out_char[7:0], chars_so_far[39:8] | run_end
//
// Each request is decoded as it is accepted, then a numeric conversion produces
// one digit per cycle, then the characters go out one per cycle while m_tready
// does not stall the output register; a request that only arms the percent
// flag ends with its decode. The digit loop divides by ten through the
// reciprocal multiplier for decimal and shifts for octal and hex. Reset is
// synchronous, active low, and clears the percent flag and the running total. A
// stalled m_tready holds the output register and pauses the character stream.
module format_integer_to_ascii_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [fita_pkg::S_DATA_W-1:0]  s_tdata,  // fmt_char, arg_value
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [fita_pkg::M_DATA_W-1:0]  m_tdata,  // out_char, chars_so_far
    output logic                           m_tlast
);

    fita_pkg::fita_cmd_t    cmd;
    fita_pkg::fita_status_t status;

    // Controller.
    fita_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .status   (status)
    );

    // Datapath.
    fita_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// File: dv/format_integer_to_ascii_unit_tb.sv
// Testbench for the format integer to ASCII unit: streams format bytes and
// arguments in, predicts every produced character and checks it on the way out.
// Depends on fita_pkg and format_integer_to_ascii_unit.
`timescale 1ns / 100ps

module format_integer_to_ascii_unit_tb;

    // Conversion characters that the package does not name.
    localparam logic [fita_pkg::CHAR_W-1:0] CHAR_LOWER_C = 8'h63;
    localparam logic [fita_pkg::CHAR_W-1:0] CHAR_LOWER_S = 8'h73;
    localparam logic [fita_pkg::CHAR_W-1:0] CHAR_LOWER_Q = 8'h71;
    localparam logic [fita_pkg::CHAR_W-1:0] CHAR_NULL    = 8'h00;

    // Digit lookup tables, index 0 in the top byte.
    localparam logic [8*16-1:0] LOWER_TABLE = "0123456789abcdef";
    localparam logic [8*16-1:0] UPPER_TABLE = "0123456789ABCDEF";

    localparam int REPORT_LIMIT = 10;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 40;

    // One produced character as seen on the result channel.
    typedef struct packed {
        logic [fita_pkg::CHAR_W-1:0]  ch;
        logic                         last;
        logic [fita_pkg::TOTAL_W-1:0] total;
    } out_char_t;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [fita_pkg::S_DATA_W-1:0]   s_tdata = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [fita_pkg::M_DATA_W-1:0]   m_tdata;
    logic                            m_tlast;

    // Predictor state.
    logic                            percent_armed = 1'b0;
    logic [fita_pkg::TOTAL_W-1:0]    char_total = '0;
    out_char_t                       expected_chars[$];

    // Traffic shaping and bookkeeping.
    int                    sender_idle_pct = 0;
    int                    rcv_stall_pct = 0;
    logic                  holding = 1'b0;
    event                  start_long_hold;
    int                    requests_sent = 0;
    int                    requests_taken = 0;
    int                    results_checked = 0;
    int                    mismatches = 0;
    out_char_t             seen;
    out_char_t             want;

    format_integer_to_ascii_unit DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // fmt_char, arg_value
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // out_char, chars_so_far
        .m_tlast  (m_tlast)
    );

    always #2 aclk = ~aclk;

    // Works out the characters that one accepted request produces.
    function automatic void predict_request(input logic [fita_pkg::CHAR_W-1:0] fc,
                                            input logic [fita_pkg::VALUE_W-1:0] av);
        logic [fita_pkg::CHAR_W-1:0]  line_chars [0:fita_pkg::MAX_DIGITS-1];
        logic [fita_pkg::DIGIT_W-1:0] digits [0:fita_pkg::MAX_DIGITS-1];
        logic [fita_pkg::VALUE_W-1:0] mag;
        logic [fita_pkg::VALUE_W-1:0] radix;
        logic [fita_pkg::VALUE_W-1:0] rem;
        logic [8*16-1:0]              table_bits;
        int                           n_chars;
        int                           n_digits;
        int                           k;
        out_char_t                    entry;
        n_chars = 0;
        radix = '0;
        mag = av;
        table_bits = LOWER_TABLE;
        if (!percent_armed) begin
            if (fc == fita_pkg::CHAR_PERCENT) begin
                percent_armed = 1'b1;
                return;
            end
            line_chars[0] = fc;
            n_chars = 1;
        end else begin
            percent_armed = 1'b0;
            case (fc)
                fita_pkg::CHAR_D, fita_pkg::CHAR_I: begin
                    radix = 32'd10;
                    if (av[fita_pkg::VALUE_W-1]) begin
                        line_chars[0] = fita_pkg::CHAR_MINUS;
                        n_chars = 1;
                        mag = ~av + 32'd1;
                    end
                end
                fita_pkg::CHAR_U: radix = 32'd10;
                fita_pkg::CHAR_O: radix = 32'd8;
                fita_pkg::CHAR_X_LOW: radix = 32'd16;
                fita_pkg::CHAR_X_UP: begin
                    radix = 32'd16;
                    table_bits = UPPER_TABLE;
                end
                fita_pkg::CHAR_PERCENT: begin
                    line_chars[0] = fita_pkg::CHAR_PERCENT;
                    n_chars = 1;
                end
                default: begin
                    line_chars[0] = fita_pkg::CHAR_PERCENT;
                    line_chars[1] = fc;
                    n_chars = 2;
                end
            endcase
        end
        // Digits are found least significant first and listed the other way.
        if (radix != 0) begin
            n_digits = 0;
            do begin
                rem = mag % radix;
                digits[n_digits] = rem[fita_pkg::DIGIT_W-1:0];
                mag = mag / radix;
                n_digits++;
            end while (mag != 0);
            for (k = n_digits - 1; k >= 0; k--) begin
                line_chars[n_chars] = table_bits[8*(15 - digits[k]) +: 8];
                n_chars++;
            end
        end
        // The running total saturates; the last character closes the run.
        for (k = 0; k < n_chars; k++) begin
            if (char_total != '1) begin
                char_total = char_total + 32'd1;
            end
            entry.ch = line_chars[k];
            entry.last = (k == n_chars - 1);
            entry.total = char_total;
            expected_chars.push_back(entry);
        end
    endfunction

    // Predict from every request that the block accepts.
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            requests_taken++;
            predict_request(s_tdata[fita_pkg::CHAR_W-1:0],
                            s_tdata[fita_pkg::S_DATA_W-1:fita_pkg::CHAR_W]);
        end
    end

    // Compare each accepted character with the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            seen.ch = m_tdata[fita_pkg::CHAR_W-1:0];
            seen.last = m_tlast;
            seen.total = m_tdata[fita_pkg::M_DATA_W-1:fita_pkg::CHAR_W];
            results_checked++;
            if (expected_chars.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("unexpected character: char=%h last=%b total=%0d",
                             seen.ch, seen.last, seen.total);
                end
            end else begin
                want = expected_chars.pop_front();
                if (seen.ch !== want.ch || seen.last !== want.last ||
                    seen.total !== want.total) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display({"mismatch: expected char=%h last=%b total=%0d,",
                                  " got char=%h last=%b total=%0d"},
                                 want.ch, want.last, want.total,
                                 seen.ch, seen.last, seen.total);
                    end
                end
            end
        end
    end

    // Receiver: random stalls, or a forced hold-off while one is running.
    always @(posedge aclk) begin
        if (holding) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= rcv_stall_pct);
        end
    end

    // Long hold-off of the receiver, counted here in clock cycles.
    always begin
        @(start_long_hold);
        holding <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge aclk);
        holding <= 1'b0;
    end

    // Offers one request and returns at the edge where it is accepted.
    task automatic send_request(input logic [fita_pkg::CHAR_W-1:0] fc,
                                input logic [fita_pkg::VALUE_W-1:0] av);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {av, fc};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        requests_sent++;
    endtask

    task automatic send_conversion(input logic [fita_pkg::CHAR_W-1:0] conv,
                                   input logic [fita_pkg::VALUE_W-1:0] av);
        send_request(fita_pkg::CHAR_PERCENT, $urandom);
        send_request(conv, av);
    endtask

    function automatic logic [fita_pkg::VALUE_W-1:0] random_value();
        logic [fita_pkg::VALUE_W-1:0] v;
        case ($urandom_range(0, 4))
            0: v = $urandom_range(0, 9);
            1: v = $urandom;
            2: v = 32'h8000_0000 | $urandom_range(0, 255);
            3: v = $urandom >> $urandom_range(0, 31);
            default: begin
                case ($urandom_range(0, 3))
                    0: v = 32'h0000_0000;
                    1: v = 32'hFFFF_FFFF;
                    2: v = 32'h8000_0000;
                    default: v = 32'h7FFF_FFFF;
                endcase
            end
        endcase
        return v;
    endfunction

    function automatic logic [fita_pkg::CHAR_W-1:0] random_conversion();
        logic [fita_pkg::CHAR_W-1:0] c;
        case ($urandom_range(0, 5))
            0: c = fita_pkg::CHAR_D;
            1: c = fita_pkg::CHAR_I;
            2: c = fita_pkg::CHAR_U;
            3: c = fita_pkg::CHAR_O;
            4: c = fita_pkg::CHAR_X_LOW;
            default: c = fita_pkg::CHAR_X_UP;
        endcase
        return c;
    endfunction

    // Mostly well-formed conversions, with echoed bytes and odd escapes mixed in.
    task automatic send_random_sequence();
        int                          pick;
        logic [fita_pkg::CHAR_W-1:0] b;
        pick = $urandom_range(0, 99);
        b = fita_pkg::CHAR_W'($urandom_range(0, 255));
        if (pick < 70) begin
            send_conversion(random_conversion(), random_value());
        end else if (pick < 85) begin
            send_request(b, $urandom);
        end else begin
            send_conversion(b, $urandom);
        end
    endtask

    // Plain bytes are echoed, the null byte and the top code included.
    task automatic test_echo();
        send_request(8'h41, 32'hFFFF_FFFF);
        send_request(8'hFF, 32'h0000_0000);
        send_request(CHAR_NULL, $urandom);
    endtask

    // Every numeric conversion, with the most negative value and zero.
    task automatic test_conversions();
        send_conversion(fita_pkg::CHAR_D, 32'h8000_0000);
        send_conversion(fita_pkg::CHAR_D, 32'hFFFF_FFFF);
        send_conversion(fita_pkg::CHAR_I, 32'h0000_0000);
        send_conversion(fita_pkg::CHAR_U, 32'hFFFF_FFFF);
        send_conversion(fita_pkg::CHAR_O, 32'hFFFF_FFFF);
        send_conversion(fita_pkg::CHAR_X_LOW, 32'hDEAD_BEEF);
        send_conversion(fita_pkg::CHAR_X_UP, 32'hABCD_EF01);
    endtask

    // Literal percent, and c, s and the null byte taken as unknown conversions.
    task automatic test_percent_escapes();
        send_conversion(fita_pkg::CHAR_PERCENT, $urandom);
        send_conversion(CHAR_LOWER_C, $urandom);
        send_conversion(CHAR_LOWER_S, $urandom);
        send_conversion(CHAR_NULL, $urandom);
    endtask

    // Receiver holds off while the sender keeps offering long conversions.
    task automatic test_output_backpressure();
        int k;
        sender_idle_pct = 0;
        rcv_stall_pct = 0;
        -> start_long_hold;
        for (k = 0; k < 6; k++) begin
            send_conversion(fita_pkg::CHAR_O, 32'hFFFF_FFFF - k);
        end
        send_conversion(CHAR_LOWER_Q, 32'h0);
    endtask

    task automatic test_random_phase(input int s_idle, input int r_stall, input int n_items);
        int start;
        sender_idle_pct = s_idle;
        rcv_stall_pct = r_stall;
        start = requests_sent;
        while (requests_sent - start < n_items) begin
            send_random_sequence();
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_echo();
        test_conversions();
        test_percent_escapes();
        test_output_backpressure();
        test_random_phase(0, 0, 20);
        test_random_phase(79, 0, 20);
        test_random_phase(0, 79, 20);
        test_random_phase(34, 34, 20);

        // Let the last characters drain out.
        s_tvalid <= 1'b0;
        sender_idle_pct = 0;
        rcv_stall_pct = 0;
        while (expected_chars.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Covered %0d requests (echo, all conversions, escapes, long hold-off),",
                 requests_taken);
        $display("checked %0d characters under four idle and stall mixes, %0d mismatches.",
                 results_checked, mismatches);
        if (mismatches == 0 && expected_chars.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
